FILE: rtl/mbjr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbjr_pkg
// Shared types and instruction codes for the branch and jump resolver.
// ----------------------------------------------------------------------------
package mbjr_pkg;

  // major opcodes
  localparam logic [5:0] OpSpecial = 6'd0;
  localparam logic [5:0] OpRegimm  = 6'd1;
  localparam logic [5:0] OpJ       = 6'd2;
  localparam logic [5:0] OpJal     = 6'd3;
  localparam logic [5:0] OpBeq     = 6'd4;
  localparam logic [5:0] OpBne     = 6'd5;
  localparam logic [5:0] OpBlez    = 6'd6;
  localparam logic [5:0] OpBgtz    = 6'd7;
  localparam logic [5:0] OpCop0    = 6'd16;
  localparam logic [5:0] OpCop1    = 6'd17;
  localparam logic [5:0] OpBeql    = 6'd20;
  localparam logic [5:0] OpBnel    = 6'd21;
  localparam logic [5:0] OpBlezl   = 6'd22;
  localparam logic [5:0] OpBgtzl   = 6'd23;
  localparam logic [5:0] OpJalx    = 6'd29;

  // special function codes
  localparam logic [5:0] FnJr      = 6'd8;
  localparam logic [5:0] FnJalr    = 6'd9;
  localparam logic [5:0] FnSyscall = 6'd12;
  localparam logic [5:0] FnSdbbp   = 6'd15;

  // shift amount that marks a hazard-barrier jump
  localparam logic [4:0] SaHazard  = 5'd16;

  // regimm rt codes
  localparam logic [4:0] RtBltz    = 5'd0;
  localparam logic [4:0] RtBgez    = 5'd1;
  localparam logic [4:0] RtBltzl   = 5'd2;
  localparam logic [4:0] RtBgezl   = 5'd3;
  localparam logic [4:0] RtBltzal  = 5'd16;
  localparam logic [4:0] RtBgezal  = 5'd17;
  localparam logic [4:0] RtBltzall = 5'd18;
  localparam logic [4:0] RtBgezall = 5'd19;
  localparam logic [4:0] RtSynci   = 5'd31;

  // cop0 rs codes
  localparam logic [4:0] RsMfc0    = 5'd0;
  localparam logic [4:0] RsMtc0    = 5'd4;

  // return address register
  localparam logic [4:0] RegRa     = 5'd31;

  typedef enum logic [1:0] {
    ST_REFUSED  = 2'd0,
    ST_NOT_EMUL = 2'd1,
    ST_SLOT     = 2'd2,
    ST_NO_SLOT  = 2'd3
  } status_e;

  typedef struct packed {
    status_e     status;
    logic [31:0] next_pc;
    logic        link_write;
    logic [4:0]  link_index;
    logic [31:0] link_value;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/mbjr_decode.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mbjr_decode
// Combinational resolution of one instruction into next PC, link and status.
// ----------------------------------------------------------------------------
module mbjr_decode
  import mbjr_pkg::*;
(
  input  wire logic [31:0] instruction_i,
  input  wire logic [31:0] pc_i,
  input  wire logic [31:0] rs_value_i,
  input  wire logic [31:0] rt_value_i,
  output result_t          result_o
);

  logic [5:0]  op;
  logic [4:0]  rs;
  logic [4:0]  rt;
  logic [4:0]  rd;
  logic [4:0]  sa;
  logic [5:0]  fn;
  logic [31:0] pc_plus4;
  logic [31:0] link;
  logic [31:0] br_target;
  logic [31:0] jmp_target;
  logic        neg;
  logic        zero;
  logic        equal;
  logic        is_branch;
  logic        taken;
  logic        likely;
  logic        lnk;

  // field extraction
  assign op = instruction_i[31:26];
  assign rs = instruction_i[25:21];
  assign rt = instruction_i[20:16];
  assign rd = instruction_i[15:11];
  assign sa = instruction_i[10:6];
  assign fn = instruction_i[5:0];

  // address arithmetic
  assign pc_plus4   = pc_i + 32'd4;
  assign link       = pc_i + 32'd8;
  assign br_target  = pc_plus4 + {{14{instruction_i[15]}}, instruction_i[15:0], 2'b00};
  assign jmp_target = {pc_plus4[31:28], instruction_i[25:0], 2'b00};

  // compare conditions
  assign neg   = rs_value_i[31];
  assign zero  = (rs_value_i == 32'd0);
  assign equal = (rs_value_i == rt_value_i);

  // opcode decode
  always_comb begin
    result_o   = '{status: ST_NOT_EMUL, next_pc: pc_i, link_write: 1'b0,
                   link_index: 5'd0, link_value: 32'd0};
    is_branch  = 1'b0;
    taken      = 1'b0;
    likely     = 1'b0;
    lnk        = 1'b0;
    case (op)
      OpSpecial: begin
        if (fn == FnJr || fn == FnJalr) begin
          if (sa == SaHazard) begin
            result_o.status = ST_REFUSED;
          end else if (fn == FnJr) begin
            result_o.status  = ST_SLOT;
            result_o.next_pc = rs_value_i;
          end else begin
            result_o.status     = ST_SLOT;
            result_o.next_pc    = (rd == rs) ? link : rs_value_i;
            result_o.link_write = 1'b1;
            result_o.link_index = rd;
            result_o.link_value = link;
          end
        end else if (fn inside {[FnSyscall:FnSdbbp]}) begin
          result_o.status = ST_REFUSED;
        end
      end
      OpRegimm: begin
        is_branch = 1'b1;
        case (rt)
          RtBltz:    taken = neg;
          RtBgez:    taken = !neg;
          RtBltzl:   begin taken = neg;  likely = 1'b1; end
          RtBgezl:   begin taken = !neg; likely = 1'b1; end
          RtBltzal:  begin taken = neg;  lnk = 1'b1; end
          RtBgezal:  begin taken = !neg; lnk = 1'b1; end
          RtBltzall: begin taken = neg;  lnk = 1'b1; likely = 1'b1; end
          RtBgezall: begin taken = !neg; lnk = 1'b1; likely = 1'b1; end
          default: begin
            is_branch       = 1'b0;
            result_o.status = (rt == RtSynci) ? ST_REFUSED : ST_NOT_EMUL;
          end
        endcase
      end
      OpJ, OpJal: begin
        result_o.status  = ST_SLOT;
        result_o.next_pc = jmp_target;
        if (op == OpJal) begin
          result_o.link_write = 1'b1;
          result_o.link_index = RegRa;
          result_o.link_value = link;
        end
      end
      OpBeq:   begin is_branch = 1'b1; taken = equal; end
      OpBne:   begin is_branch = 1'b1; taken = !equal; end
      OpBlez:  begin is_branch = 1'b1; taken = neg || zero; end
      OpBgtz:  begin is_branch = 1'b1; taken = !neg && !zero; end
      OpBeql:  begin is_branch = 1'b1; taken = equal;          likely = 1'b1; end
      OpBnel:  begin is_branch = 1'b1; taken = !equal;         likely = 1'b1; end
      OpBlezl: begin is_branch = 1'b1; taken = neg || zero;    likely = 1'b1; end
      OpBgtzl: begin is_branch = 1'b1; taken = !neg && !zero;  likely = 1'b1; end
      OpCop0: begin
        result_o.status = (rs == RsMfc0 || rs == RsMtc0) ? ST_NOT_EMUL : ST_REFUSED;
      end
      OpCop1, OpJalx: begin
        result_o.status = ST_REFUSED;
      end
      default: begin
        result_o.status = ST_NOT_EMUL;
      end
    endcase

    // conditional branch outcome
    if (is_branch) begin
      if (taken) begin
        result_o.status  = ST_SLOT;
        result_o.next_pc = br_target;
        if (lnk) begin
          result_o.link_write = 1'b1;
          result_o.link_index = RegRa;
          result_o.link_value = link;
        end
      end else begin
        result_o.status  = ST_NO_SLOT;
        result_o.next_pc = likely ? link : pc_plus4;
      end
    end
  end

endmodule
`default_nettype wire

FILE: rtl/mips_branch_jump_resolver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mips_branch_jump_resolver_core
// Resolves MIPS jumps and branches into next PC, link write and status.
// ----------------------------------------------------------------------------
// Accepts one instruction per cycle while not stalled and returns one result for
// each. An accepted instruction lands in the input register, is resolved by the
// decode logic and is held in the result register, from which it is offered;
// the result register only loads when it is empty or the output is not stalled.
// The input register takes a new instruction while an earlier result waits to
// be collected only if it is empty itself. The block holds no state beyond these
// two stages.
module mips_branch_jump_resolver_core
  import mbjr_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // input channel
  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic [31:0] instruction_i,
  input  wire logic [31:0] pc_i,
  input  wire logic [31:0] rs_value_i,
  input  wire logic [31:0] rt_value_i,
  // output channel
  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [1:0]  status_o,
  output      logic [31:0] next_pc_o,
  output      logic        link_write_o,
  output      logic [4:0]  link_index_o,
  output      logic [31:0] link_value_o
);

  logic        in_valid_q;
  logic [31:0] ins_q;
  logic [31:0] pc_q;
  logic [31:0] rs_q;
  logic [31:0] rt_q;
  logic        res_valid_q;
  result_t     res_q;
  result_t     res_d;
  logic        res_ready;
  logic        in_ready;

  // stage advance
  assign res_ready  = !res_valid_q || !out_stall_i;
  assign in_ready   = !in_valid_q || res_ready;
  assign in_stall_o = !in_ready;

  // input register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready) begin
      in_valid_q <= in_valid_i;
    end
  end

  // input register payload
  always_ff @(posedge clk_i) begin
    if (in_ready && in_valid_i) begin
      ins_q <= instruction_i;
      pc_q  <= pc_i;
      rs_q  <= rs_value_i;
      rt_q  <= rt_value_i;
    end
  end

  // resolution logic
  mbjr_decode u_decode (
    .instruction_i (ins_q),
    .pc_i          (pc_q),
    .rs_value_i    (rs_q),
    .rt_value_i    (rt_q),
    .result_o      (res_d)
  );

  // result register control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (res_ready) begin
      res_valid_q <= in_valid_q;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (res_ready && in_valid_q) begin
      res_q <= res_d;
    end
  end

  // outputs
  assign out_valid_o  = res_valid_q;
  assign status_o     = res_q.status;
  assign next_pc_o    = res_q.next_pc;
  assign link_write_o = res_q.link_write;
  assign link_index_o = res_q.link_index;
  assign link_value_o = res_q.link_value;

  // link fields are clear unless a link is written
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !link_write_o |-> link_index_o == 5'd0 && link_value_o == 32'd0)
    else $error("link fields set without link write");

  // a link write only comes with a taken transfer
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && link_write_o |-> status_o == ST_SLOT)
    else $error("link write on a non-taken result");

  // a held instruction is not dropped while the result stage is blocked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !res_ready |=> in_valid_q && $stable(ins_q) && $stable(pc_q))
    else $error("input stage lost an instruction under stall");

endmodule
`default_nettype wire

FILE: sim/tb_mips_branch_jump_resolver_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_mips_branch_jump_resolver_core
// Self-checking bench for the branch and jump resolver core.
// ----------------------------------------------------------------------------
// A queue of instruction transfers is filled up front: a directed set of
// jumps, branches, refused and unemulated codes at their edges, then
// random instructions that are mostly well-formed control transfers. A
// clocked driver offers them with random gaps. A clocked receiver stalls
// at random and once holds off for a long stretch. Every accepted
// instruction is resolved by a local model of the branch unit, and every
// result transfer is checked field by field against the oldest prediction.
module tb_mips_branch_jump_resolver_core;
  import mbjr_pkg::*;

  // codes the package does not name
  localparam logic [5:0] FnBreak  = 6'd13;
  localparam logic [5:0] FnAddu   = 6'd33;
  localparam logic [4:0] RtTgei   = 5'd8;
  localparam logic [4:0] RsCop0Mf = 5'd1;
  localparam logic [5:0] OpTop    = 6'd63;

  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned ChunkSize  = 110;
  localparam int unsigned ShowMax    = 10;

  typedef struct {
    logic [31:0] instr;
    logic [31:0] pc;
    logic [31:0] rs_val;
    logic [31:0] rt_val;
    int unsigned gap;
  } branch_req_t;

  // dut ports
  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        in_valid_i    = 1'b0;
  logic        in_stall_o;
  logic [31:0] instruction_i = '0;
  logic [31:0] pc_i          = '0;
  logic [31:0] rs_value_i    = '0;
  logic [31:0] rt_value_i    = '0;
  logic        out_valid_o;
  logic        out_stall_i   = 1'b0;
  logic [1:0]  status_o;
  logic [31:0] next_pc_o;
  logic        link_write_o;
  logic [4:0]  link_index_o;
  logic [31:0] link_value_o;

  // bench state
  branch_req_t req_q[$];
  result_t     resolved_q[$];
  int unsigned gap_max     = 0;
  int unsigned errors      = 0;
  int unsigned cycle_cnt   = 0;
  int unsigned in_count    = 0;
  int unsigned drv_idle    = 0;
  logic        in_fire     = 1'b0;
  logic        out_fire    = 1'b0;
  int unsigned rcv_wait    = 0;
  int unsigned rcv_draw    = 0;
  int unsigned rcv_count   = 0;
  logic        rcv_busy    = 1'b1;
  int unsigned hold_left   = 0;
  logic        hold_done   = 1'b0;

  mips_branch_jump_resolver_core dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .instruction_i(instruction_i),
    .pc_i         (pc_i),
    .rs_value_i   (rs_value_i),
    .rt_value_i   (rt_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .next_pc_o    (next_pc_o),
    .link_write_o (link_write_o),
    .link_index_o (link_index_o),
    .link_value_o (link_value_o)
  );

  // clock
  always #5 clk_i = ~clk_i;

  // resolve one instruction into its expected result
  function automatic result_t resolve_branch(logic [31:0] ins, logic [31:0] pc,
                                             logic [31:0] vs, logic [31:0] vt);
    result_t     r;
    logic [5:0]  op;
    logic [5:0]  fn;
    logic [4:0]  rs;
    logic [4:0]  rt;
    logic [4:0]  rd;
    logic [4:0]  sa;
    logic [31:0] link;
    logic [31:0] pc4;
    logic [31:0] off;
    logic        neg;
    logic        zero;
    logic        taken;
    logic        likely;
    logic        lnk;
    logic        cond;
    op     = ins[31:26];
    rs     = ins[25:21];
    rt     = ins[20:16];
    rd     = ins[15:11];
    sa     = ins[10:6];
    fn     = ins[5:0];
    link   = pc + 32'd8;
    pc4    = pc + 32'd4;
    neg    = vs[31];
    zero   = (vs == 32'd0);
    taken  = 1'b0;
    likely = 1'b0;
    lnk    = 1'b0;
    cond   = 1'b0;
    r.status     = ST_NOT_EMUL;
    r.next_pc    = pc;
    r.link_write = 1'b0;
    r.link_index = '0;
    r.link_value = '0;
    case (op)
      OpSpecial: begin
        if (fn == FnJr || fn == FnJalr) begin
          if (sa == SaHazard) begin
            r.status = ST_REFUSED;
          end else if (fn == FnJr) begin
            r.status  = ST_SLOT;
            r.next_pc = vs;
          end else begin
            r.status     = ST_SLOT;
            r.next_pc    = (rd == rs) ? link : vs;
            r.link_write = 1'b1;
            r.link_index = rd;
            r.link_value = link;
          end
        end else if (fn >= FnSyscall && fn <= FnSdbbp) begin
          r.status = ST_REFUSED;
        end
      end
      OpRegimm: begin
        cond = 1'b1;
        case (rt)
          RtBltz:    taken = neg;
          RtBgez:    taken = !neg;
          RtBltzl:   begin taken = neg;  likely = 1'b1; end
          RtBgezl:   begin taken = !neg; likely = 1'b1; end
          RtBltzal:  begin taken = neg;  lnk = 1'b1; end
          RtBgezal:  begin taken = !neg; lnk = 1'b1; end
          RtBltzall: begin taken = neg;  lnk = 1'b1; likely = 1'b1; end
          RtBgezall: begin taken = !neg; lnk = 1'b1; likely = 1'b1; end
          default: begin
            cond = 1'b0;
            if (rt == RtSynci) r.status = ST_REFUSED;
            else r.status = ST_NOT_EMUL;
          end
        endcase
      end
      OpJ, OpJal: begin
        r.status  = ST_SLOT;
        r.next_pc = {pc4[31:28], ins[25:0], 2'b00};
        if (op == OpJal) begin
          r.link_write = 1'b1;
          r.link_index = RegRa;
          r.link_value = link;
        end
      end
      OpBeq:   begin cond = 1'b1; taken = (vs == vt); end
      OpBne:   begin cond = 1'b1; taken = (vs != vt); end
      OpBlez:  begin cond = 1'b1; taken = neg || zero; end
      OpBgtz:  begin cond = 1'b1; taken = !neg && !zero; end
      OpBeql:  begin cond = 1'b1; taken = (vs == vt); likely = 1'b1; end
      OpBnel:  begin cond = 1'b1; taken = (vs != vt); likely = 1'b1; end
      OpBlezl: begin cond = 1'b1; taken = neg || zero; likely = 1'b1; end
      OpBgtzl: begin cond = 1'b1; taken = !neg && !zero; likely = 1'b1; end
      OpCop0: begin
        if (rs == RsMfc0 || rs == RsMtc0) r.status = ST_NOT_EMUL;
        else r.status = ST_REFUSED;
      end
      OpCop1, OpJalx: r.status = ST_REFUSED;
      default: r.status = ST_NOT_EMUL;
    endcase
    // conditional branch outcome
    if (cond) begin
      if (taken) begin
        off       = {{14{ins[15]}}, ins[15:0], 2'b00};
        r.status  = ST_SLOT;
        r.next_pc = pc4 + off;
        if (lnk) begin
          r.link_write = 1'b1;
          r.link_index = RegRa;
          r.link_value = link;
        end
      end else begin
        r.status  = ST_NO_SLOT;
        r.next_pc = likely ? link : pc4;
      end
    end
    return r;
  endfunction

  // instruction encoders
  function automatic logic [31:0] enc_imm(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
    return {op, rs, rt, imm};
  endfunction

  function automatic logic [31:0] enc_spec(logic [4:0] rs, logic [4:0] rt, logic [4:0] rd,
                                           logic [4:0] sa, logic [5:0] fn);
    return {OpSpecial, rs, rt, rd, sa, fn};
  endfunction

  // register values biased toward sign and zero edges
  function automatic logic [31:0] rand_word();
    case ($urandom_range(0, 7))
      0: return 32'h0000_0000;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: return 32'($urandom_range(0, 16));
      default: return $urandom();
    endcase
  endfunction

  // mostly well-formed control transfers, some noise
  function automatic logic [31:0] rand_instr();
    logic [31:0] w;
    int unsigned pick;
    w = $urandom();
    case ($urandom_range(0, 19))
      0, 1, 2: begin
        w[31:26] = OpSpecial;
        pick = $urandom_range(0, 7);
        if (pick < 3) w[5:0] = FnJalr;
        else if (pick < 5) w[5:0] = FnJr;
        if ($urandom_range(0, 3) == 0) w[10:6] = SaHazard;
        if ($urandom_range(0, 3) == 0) w[15:11] = w[25:21];
      end
      3, 4, 5: begin
        w[31:26] = OpRegimm;
        case ($urandom_range(0, 9))
          0: w[20:16] = RtBltz;
          1: w[20:16] = RtBgez;
          2: w[20:16] = RtBltzl;
          3: w[20:16] = RtBgezl;
          4: w[20:16] = RtBltzal;
          5: w[20:16] = RtBgezal;
          6: w[20:16] = RtBltzall;
          7: w[20:16] = RtBgezall;
          8: w[20:16] = RtSynci;
          default: ;
        endcase
      end
      6: w[31:26] = OpJ;
      7: w[31:26] = OpJal;
      8:  w[31:26] = OpBeq;
      9:  w[31:26] = OpBne;
      10: w[31:26] = OpBlez;
      11: w[31:26] = OpBgtz;
      12: w[31:26] = OpBeql;
      13: w[31:26] = OpBnel;
      14: w[31:26] = OpBlezl;
      15: w[31:26] = OpBgtzl;
      16: begin
        w[31:26] = OpCop0;
        pick = $urandom_range(0, 2);
        if (pick == 0) w[25:21] = RsMfc0;
        else if (pick == 1) w[25:21] = RsMtc0;
      end
      default: ;
    endcase
    return w;
  endfunction

  // queue one instruction with a gap drawn for it
  task automatic push_req(logic [31:0] instr, logic [31:0] pc, logic [31:0] rs_val,
                          logic [31:0] rt_val);
    branch_req_t req;
    req.instr  = instr;
    req.pc     = pc;
    req.rs_val = rs_val;
    req.rt_val = rt_val;
    req.gap    = $urandom_range(0, gap_max);
    req_q.push_back(req);
  endtask

  // compare one result transfer with the oldest prediction
  task automatic check_result();
    result_t exp;
    logic    bad;
    if (resolved_q.size() == 0) begin
      errors++;
      if (errors <= ShowMax)
        $display("unexpected result: status %0d next_pc %h", status_o, next_pc_o);
    end else begin
      exp = resolved_q.pop_front();
      bad = (status_o !== exp.status) || (next_pc_o !== exp.next_pc) ||
            (link_write_o !== exp.link_write) || (link_index_o !== exp.link_index) ||
            (link_value_o !== exp.link_value);
      if (bad) begin
        errors++;
        if (errors <= ShowMax) begin
          $display("result mismatch: exp st %0d npc %h lw %b li %0d lv %h",
                   exp.status, exp.next_pc, exp.link_write, exp.link_index,
                   exp.link_value);
          $display("                 got st %0d npc %h lw %b li %0d lv %h",
                   status_o, next_pc_o, link_write_o, link_index_o, link_value_o);
        end
      end
    end
  endtask

  // input transfer: predict and count
  always @(posedge clk_i) begin
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      resolved_q.push_back(resolve_branch(instruction_i, pc_i, rs_value_i, rt_value_i));
      in_count <= in_count + 1;
    end
  end

  // output transfer: check
  always @(posedge clk_i) begin
    out_fire <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni && out_valid_o && !out_stall_i) check_result();
  end

  // driver: hold a stalled item, otherwise idle out the gap and offer the next
  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_fire)) begin
      if (req_q.size() != 0) begin
        if (drv_idle < req_q[0].gap) begin
          drv_idle   <= drv_idle + 1;
          in_valid_i <= 1'b0;
        end else begin
          instruction_i <= req_q[0].instr;
          pc_i          <= req_q[0].pc;
          rs_value_i    <= req_q[0].rs_val;
          rt_value_i    <= req_q[0].rt_val;
          in_valid_i    <= 1'b1;
          drv_idle      <= 0;
          void'(req_q.pop_front());
        end
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // long receiver hold-off once the run is under way
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && in_count >= 200) begin
      hold_left <= HoldCycles;
      hold_done <= 1'b1;
    end
  end

  // receiver: random stall per result, busy and quiet stretches alternate
  always @(negedge clk_i) begin
    rcv_draw = rcv_wait;
    if (out_fire) begin
      rcv_count <= rcv_count + 1;
      if (rcv_count % 40 == 39) rcv_busy <= ~rcv_busy;
      rcv_draw = rcv_busy ? $urandom_range(0, 10) : 0;
    end
    if (hold_left > 0) begin
      out_stall_i <= 1'b1;
      rcv_wait    <= rcv_draw;
    end else if (rcv_draw > 0) begin
      out_stall_i <= 1'b1;
      rcv_wait    <= rcv_draw - 1;
    end else begin
      out_stall_i <= 1'b0;
      rcv_wait    <= 0;
    end
  end

  // timeout
  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // stimulus and end of run
  initial begin
    logic [31:0] rs_v;
    gap_max = 3;
    // jr, jr barrier, jalr forms
    push_req(enc_spec(5'd2, 5'd0, 5'd0, 5'd0, FnJr), 32'h0000_1000, 32'h8000_0000, 32'h0);
    push_req(enc_spec(5'd2, 5'd0, 5'd0, SaHazard, FnJr), 32'h0000_1000, 32'h1234_5678, 32'h0);
    push_req(enc_spec(5'd4, 5'd0, RegRa, 5'd0, FnJalr), 32'hffff_fffc, 32'hdead_beec, 32'h0);
    push_req(enc_spec(5'd7, 5'd0, 5'd7, 5'd0, FnJalr), 32'h0040_0000, 32'h0000_0ff0, 32'h0);
    push_req(enc_spec(5'd3, 5'd0, 5'd0, 5'd0, FnJalr), 32'h0040_0010, 32'hffff_ffff, 32'h0);
    push_req(enc_spec(5'd3, 5'd0, RegRa, SaHazard, FnJalr), 32'h0040_0020, 32'h4, 32'h0);
    // trap-like special codes and an ordinary alu op
    push_req(enc_spec(5'd0, 5'd0, 5'd0, 5'd0, FnSyscall), 32'h0000_2000, 32'h0, 32'h0);
    push_req(enc_spec(5'd0, 5'd0, 5'd0, 5'd0, FnBreak), 32'h0000_2004, 32'h0, 32'h0);
    push_req(enc_spec(5'd31, 5'd31, 5'd31, 5'd31, FnSdbbp), 32'h0000_2008, 32'h0, 32'h0);
    push_req(enc_spec(5'd1, 5'd2, 5'd3, 5'd0, FnAddu), 32'h0000_200c, 32'h1, 32'h2);
    // regimm branches, offset extremes and pc wrap
    push_req(enc_imm(OpRegimm, 5'd1, RtBltz, 16'h8000), 32'h0000_0000, 32'h8000_0000, 32'h0);
    push_req(enc_imm(OpRegimm, 5'd1, RtBgezal, 16'h7fff), 32'hffff_fff0, 32'h7fff_ffff, 32'h0);
    push_req(enc_imm(OpRegimm, 5'd1, RtBltzall, 16'h0010), 32'hffff_fff8, 32'h0, 32'h0);
    push_req(enc_imm(OpRegimm, 5'd0, RtSynci, 16'hffff), 32'h0000_3000, 32'h0, 32'h0);
    push_req(enc_imm(OpRegimm, 5'd0, RtTgei, 16'h0001), 32'h0000_3004, 32'h0, 32'h0);
    // region jumps across the top of memory
    push_req({OpJ, 26'h000_0000}, 32'hffff_fffc, 32'h0, 32'h0);
    push_req({OpJal, 26'h3ff_ffff}, 32'h7fff_fffc, 32'h0, 32'h0);
    // compare branches, plain and likely
    push_req(enc_imm(OpBeq, 5'd1, 5'd2, 16'hfffe), 32'h0000_4000, 32'hffff_ffff, 32'hffff_ffff);
    push_req(enc_imm(OpBne, 5'd1, 5'd2, 16'h0004), 32'h0000_4004, 32'h5, 32'h5);
    push_req(enc_imm(OpBlez, 5'd0, 5'd0, 16'h0008), 32'h0000_4008, 32'h0, 32'h0);
    push_req(enc_imm(OpBgtz, 5'd3, 5'd0, 16'h0008), 32'h0000_400c, 32'h1, 32'h0);
    push_req(enc_imm(OpBeql, 5'd1, 5'd2, 16'h0100), 32'hffff_fff8, 32'h0, 32'h1);
    push_req(enc_imm(OpBgtzl, 5'd3, 5'd0, 16'hffff), 32'h0000_4014, 32'h7fff_ffff, 32'h0);
    // coprocessor, jalx and an unused opcode
    push_req(enc_imm(OpCop0, RsMtc0, 5'd1, 16'h0), 32'h0000_5000, 32'h0, 32'h0);
    push_req(enc_imm(OpCop0, RsCop0Mf, 5'd1, 16'h0), 32'h0000_5004, 32'h0, 32'h0);
    push_req(enc_imm(OpCop1, 5'd8, 5'd1, 16'h0), 32'h0000_5008, 32'h0, 32'h0);
    push_req({OpJalx, 26'h155_5555}, 32'h0000_500c, 32'h0, 32'h0);
    push_req({OpTop, 26'h3ff_ffff}, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);

    // random part in chunks that alternate sender idling
    for (int c = 0; c < 5; c++) begin
      gap_max = (c % 2 == 0) ? 10 : 0;
      for (int i = 0; i < ChunkSize; i++) begin
        rs_v = rand_word();
        push_req(rand_instr(), rand_word(), rs_v,
                 ($urandom_range(0, 2) == 0) ? rs_v : rand_word());
      end
    end

    // reset
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // drain
    while (req_q.size() != 0 || in_valid_i) @(negedge clk_i);
    while (resolved_q.size() != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);

    errors += resolved_q.size();
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

FILE: filelist.f
rtl/mbjr_pkg.sv
rtl/mbjr_decode.sv
rtl/mips_branch_jump_resolver_core.sv
sim/tb_mips_branch_jump_resolver_core.sv
